FILE: rtl/core/acrm_pkg.sv
// acrm_pkg: shared types and constants for the ADC conversion result model.
// No dependencies; acrm_div and the top-level unit in rtl/core take names from here.

package acrm_pkg;

    // Register bit positions
    localparam int REF_SELECT_BIT = 7;
    localparam int LEFT_ALIGN_BIT = 5;

    // Divider geometry: dividend wide enough for the bandgap scale
    localparam int NUM_W = 21;
    localparam int DEN_W = 16;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int RAW_W = 10;

    // Conversion constants
    localparam logic [NUM_W-1:0] BANDGAP_SCALE   = 21'd1126400;
    localparam logic [DEN_W-1:0] MIN_SUPPLY_MV   = 16'd1500;
    localparam logic [DEN_W-1:0] THERMAL_DIVISOR = 16'd10;
    localparam logic [RAW_W-1:0] RAW_MAX         = 10'd1023;

    // Noise generator
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } acrm_state_t;

    // Control from sequencer to divider
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } acrm_div_ctrl_t;

    // Status from divider to sequencer
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quotient;
    } acrm_div_stat_t;

    // One step of the Galois LFSR
    function automatic logic [15:0] lfsr_advance(input logic [15:0] s);
        lfsr_advance = (s >> 1) ^ (s[0] ? LFSR_TAPS : 16'h0000);
    endfunction

endpackage

FILE: rtl/core/acrm_if.sv
// acrm_if: valid/ready channel interfaces for the conversion input and result words.
// Depends on nothing beyond the language; widths are those of the word fields.

interface acrm_conv_if;
    logic        valid;
    logic        ready;
    logic [7:0]  mux_register;
    logic [7:0]  control_b_register;
    logic [15:0] temperature_decikelvin;
    logic [15:0] supply_millivolts;

    modport source (
        output valid, mux_register, control_b_register,
               temperature_decikelvin, supply_millivolts,
        input  ready
    );
    modport sink (
        input  valid, mux_register, control_b_register,
               temperature_decikelvin, supply_millivolts,
        output ready
    );
endinterface

interface acrm_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_word;
    logic        thermal_channel;

    modport source (
        output valid, result_word, thermal_channel,
        input  ready
    );
    modport sink (
        input  valid, result_word, thermal_channel,
        output ready
    );
endinterface

FILE: rtl/core/adc_conversion_result_model_unit.sv
// adc_conversion_result_model_unit: top level; one word in, one result word out.
// The input word starts the divider as it is taken; the result word is registered when the divider
// reports done and is offered until taken. A new word is taken only after that result is taken; the
// shared 21-step restoring divider handles one word at a time. Input ready only when idle.
// Reset: asynchronous, active low; sequencer idle, noise LFSR seeded to 0xACE1.
// Depends on acrm_pkg, acrm_if and acrm_div.

module adc_conversion_result_model_unit (
    input  logic           clk,
    input  logic           rst_n,
    acrm_conv_if.sink      conv,
    acrm_result_if.source  result
);

    acrm_pkg::acrm_state_t   state_reg, state_next;
    logic [15:0]             lfsr_reg, lfsr_next;
    logic                    thermal_reg, thermal_next;
    logic                    left_reg, left_next;
    logic [15:0]             word_reg, word_next;
    logic                    tchan_reg, tchan_next;

    acrm_pkg::acrm_div_ctrl_t div_ctrl;
    acrm_pkg::acrm_div_stat_t div_stat;

    logic                         accept;
    logic                         thermal_in;
    logic [acrm_pkg::DEN_W-1:0]   supply_clamped;
    logic [acrm_pkg::RAW_W-1:0]   raw;

    acrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    assign accept     = conv.valid && conv.ready;
    assign thermal_in = conv.mux_register[acrm_pkg::REF_SELECT_BIT];

    // Operand selection for the divider
    always_comb
    begin
        supply_clamped = (conv.supply_millivolts < acrm_pkg::MIN_SUPPLY_MV) ?
                         acrm_pkg::MIN_SUPPLY_MV : conv.supply_millivolts;
        div_ctrl.start = accept;
        if (thermal_in)
        begin
            div_ctrl.dividend = acrm_pkg::NUM_W'(conv.temperature_decikelvin);
            div_ctrl.divisor  = acrm_pkg::THERMAL_DIVISOR;
        end
        else
        begin
            div_ctrl.dividend = acrm_pkg::BANDGAP_SCALE;
            div_ctrl.divisor  = supply_clamped;
        end
    end

    // Saturate the quotient to ten bits
    assign raw = (div_stat.quotient > acrm_pkg::NUM_W'(acrm_pkg::RAW_MAX)) ?
                 acrm_pkg::RAW_MAX : div_stat.quotient[acrm_pkg::RAW_W-1:0];

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        lfsr_next    = lfsr_reg;
        thermal_next = thermal_reg;
        left_next    = left_reg;
        word_next    = word_reg;
        tchan_next   = tchan_reg;
        conv.ready   = 1'b0;
        result.valid = 1'b0;
        case (state_reg)
            acrm_pkg::ST_IDLE:
            begin
                conv.ready = 1'b1;
                if (conv.valid)
                begin
                    thermal_next = thermal_in;
                    left_next    = conv.mux_register[acrm_pkg::LEFT_ALIGN_BIT] ||
                                   conv.control_b_register[acrm_pkg::LEFT_ALIGN_BIT];
                    lfsr_next    = acrm_pkg::lfsr_advance(lfsr_reg);
                    state_next   = acrm_pkg::ST_DIV;
                end
            end
            acrm_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    // Left aligned: raw on top, noise in the two low bits
                    if (left_reg)
                        word_next = {raw, 4'b0000, lfsr_reg[1:0]};
                    else
                        word_next = {6'b000000, raw};
                    tchan_next = thermal_reg;
                    state_next = acrm_pkg::ST_OUT;
                end
            end
            acrm_pkg::ST_OUT:
            begin
                result.valid = 1'b1;
                if (result.ready)
                    state_next = acrm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = acrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acrm_pkg::ST_IDLE;
            lfsr_reg  <= acrm_pkg::LFSR_SEED;
        end
        else
        begin
            state_reg <= state_next;
            lfsr_reg  <= lfsr_next;
        end
    end

    // Per-word payload
    always_ff @(posedge clk)
    begin
        thermal_reg <= thermal_next;
        left_reg    <= left_next;
        word_reg    <= word_next;
        tchan_reg   <= tchan_next;
    end

    assign result.result_word     = word_reg;
    assign result.thermal_channel = tchan_reg;

endmodule

FILE: rtl/core/acrm_div.sv
// acrm_div: restoring divider, one quotient bit per cycle, shared by both channels.
// Depends on acrm_pkg for widths and the control/status structs.

module acrm_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  acrm_pkg::acrm_div_ctrl_t ctrl,
    output acrm_pkg::acrm_div_stat_t stat
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [acrm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [acrm_pkg::NUM_W-1:0]  quo_reg, quo_next;
    logic [acrm_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [acrm_pkg::DEN_W-1:0]  den_reg, den_next;

    logic [acrm_pkg::DEN_W:0]    rem_sh;
    logic [acrm_pkg::DEN_W+1:0]  diff;

    // Shift in the next dividend bit and trial-subtract
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[acrm_pkg::NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    end

    // Sequencing of the iterations
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (ctrl.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = ctrl.dividend;
            rem_next  = '0;
            den_next  = ctrl.divisor;
        end
        else if (busy_reg)
        begin
            if (diff[acrm_pkg::DEN_W+1])
            begin
                rem_next = rem_sh[acrm_pkg::DEN_W-1:0];
                quo_next = {quo_reg[acrm_pkg::NUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[acrm_pkg::DEN_W-1:0];
                quo_next = {quo_reg[acrm_pkg::NUM_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == acrm_pkg::CNT_W'(acrm_pkg::NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for adc_conversion_result_model_unit. It sends conversion words,
// predicts each result word with its own noise generator and checks them in order.
// Depends on acrm_pkg, acrm_if and the RTL of the unit.

module tb_top;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 250000;
    localparam int TAIL_CYCLES = 40;

    // Own copies of the conversion constants
    localparam logic [31:0] BANDGAP_NUM  = 32'd1126400;
    localparam logic [31:0] SUPPLY_FLOOR = 32'd1500;
    localparam logic [31:0] RAW_LIMIT    = 32'd1023;
    localparam logic [15:0] NOISE_TAPS   = 16'hB400;
    localparam logic [15:0] NOISE_SEED   = 16'hACE1;

    // Mux register codes used by the directed words
    localparam logic [7:0] MUX_THERMAL = 8'h80;
    localparam logic [7:0] MUX_ALIGN   = 8'h20;
    localparam logic [7:0] MUX_NONE    = 8'h00;

    typedef struct packed {
        logic [7:0]  mux_reg;
        logic [7:0]  ctlb_reg;
        logic [15:0] decikelvin;
        logic [15:0] millivolts;
    } conv_word_t;

    typedef struct packed {
        logic [15:0] word;
        logic        thermal;
    } conv_result_t;

    logic clk;
    logic rst_n;

    acrm_conv_if   conv_ch ();
    acrm_result_if res_ch ();

    adc_conversion_result_model_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .conv   (conv_ch),
        .result (res_ch)
    );

    // Predictor state and bookkeeping
    logic [15:0]  noise_state = NOISE_SEED;
    conv_result_t predicted_results[$];
    int           error_count    = 0;
    int           words_sent     = 0;
    int           words_checked  = 0;
    int           thermal_count  = 0;
    int           left_count     = 0;
    int           clipped_count  = 0;
    int           floored_count  = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    int           stall_request  = 0;
    logic         receiver_hold  = 1'b0;
    int           cycle_count    = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Expected result of one conversion; advances the noise generator
    function automatic conv_result_t predict_conversion(input conv_word_t c);
        conv_result_t r;
        logic [31:0]  raw;
        logic [31:0]  supply;
        logic         left;
        r.thermal = c.mux_reg[acrm_pkg::REF_SELECT_BIT];
        left = c.mux_reg[acrm_pkg::LEFT_ALIGN_BIT] | c.ctlb_reg[acrm_pkg::LEFT_ALIGN_BIT];
        if (r.thermal)
        begin
            raw = {16'd0, c.decikelvin} / 32'd10;
            thermal_count++;
        end
        else
        begin
            supply = {16'd0, c.millivolts};
            if (supply < SUPPLY_FLOOR)
            begin
                supply = SUPPLY_FLOOR;
                floored_count++;
            end
            raw = BANDGAP_NUM / supply;
        end
        if (raw > RAW_LIMIT)
        begin
            raw = RAW_LIMIT;
            clipped_count++;
        end
        noise_state = {1'b0, noise_state[15:1]} ^ (noise_state[0] ? NOISE_TAPS : 16'h0000);
        if (left)
        begin
            r.word = {raw[9:0], 4'b0000, noise_state[1:0]};
            left_count++;
        end
        else
            r.word = {6'd0, raw[9:0]};
        return r;
    endfunction

    // Send one conversion word; returns once the unit has taken it
    task automatic send_conversion(input logic [7:0] mux_reg, input logic [7:0] ctlb_reg,
                                   input logic [15:0] decikelvin,
                                   input logic [15:0] millivolts);
        conv_word_t c;
        c = '{mux_reg, ctlb_reg, decikelvin, millivolts};
        if ($urandom_range(99) < send_idle_pct)
        begin
            conv_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        conv_ch.valid                  <= 1'b1;
        conv_ch.mux_register           <= c.mux_reg;
        conv_ch.control_b_register     <= c.ctlb_reg;
        conv_ch.temperature_decikelvin <= c.decikelvin;
        conv_ch.supply_millivolts      <= c.millivolts;
        @(posedge clk);
        while (!conv_ch.ready)
            @(posedge clk);
        predicted_results.push_back(predict_conversion(c));
        words_sent++;
    endtask

    // Result side: take words, compare with the oldest prediction, then pick ready
    initial
    begin : result_monitor
        conv_result_t want;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t ERROR unexpected result word: expected none, actual %h/%b",
                             $time, res_ch.result_word, res_ch.thermal_channel);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    words_checked++;
                    if (res_ch.result_word !== want.word)
                    begin
                        $display("%0t ERROR result_word: expected %h, actual %h",
                                 $time, want.word, res_ch.result_word);
                        error_count++;
                    end
                    if (res_ch.thermal_channel !== want.thermal)
                    begin
                        $display("%0t ERROR thermal_channel: expected %b, actual %b",
                                 $time, want.thermal, res_ch.thermal_channel);
                        error_count++;
                    end
                end
            end
            res_ch.ready <= !receiver_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        forever
        begin
            wait (stall_request != 0);
            receiver_hold <= 1'b1;
            repeat (stall_request) @(posedge clk);
            receiver_hold <= 1'b0;
            stall_request = 0;
        end
    end

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, predicted_results.size());
        $display("FAIL adc_conversion_result_model_unit");
        $finish;
    end

    // Thermal divide boundaries and saturation
    task automatic test_thermal_edges();
        send_conversion(MUX_THERMAL, 8'h00, 16'd0, 16'd3300);
        send_conversion(MUX_THERMAL | MUX_ALIGN, 8'h00, 16'hFFFF, 16'd0);
        send_conversion(MUX_THERMAL, 8'h00, 16'd9, 16'hFFFF);
        send_conversion(MUX_THERMAL, 8'h00, 16'd10, 16'd1500);
        send_conversion(MUX_THERMAL, 8'h20, 16'd10229, 16'd0);
        send_conversion(MUX_THERMAL, 8'h00, 16'd10239, 16'd0);
        send_conversion(MUX_THERMAL, 8'h00, 16'd10240, 16'd0);
        send_conversion(MUX_THERMAL, 8'h20, 16'd10249, 16'd0);
        send_conversion(8'hFF, 8'hFF, 16'd2981, 16'd0);
    endtask

    // Supply clamp, divide range and each alignment selection
    task automatic test_supply_and_alignment();
        send_conversion(MUX_NONE, 8'h00, 16'hFFFF, 16'd0);
        send_conversion(MUX_NONE, 8'h20, 16'd0, 16'd1499);
        send_conversion(MUX_ALIGN, 8'h20, 16'd0, 16'd1500);
        send_conversion(MUX_NONE, 8'h00, 16'd0, 16'd1501);
        send_conversion(MUX_ALIGN, 8'h00, 16'd0, 16'd1101);
        send_conversion(MUX_NONE, 8'h00, 16'd0, 16'd2200);
        send_conversion(MUX_ALIGN, 8'h00, 16'd0, 16'hFFFF);
        send_conversion(MUX_NONE, 8'h00, 16'd0, 16'hFFFF);
        // other register bits must not matter
        send_conversion(8'h5F, 8'hDF, 16'hFFFF, 16'd3000);
        send_conversion(8'h7F, 8'hDF, 16'd0, 16'd4000);
        send_conversion(8'hDF, 8'hDF, 16'd5000, 16'd1234);
    endtask

    // Receiver holds off for a long stretch; the unit fills and stalls its input
    task automatic test_result_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 400;
        repeat (8)
            send_conversion(8'($urandom_range(255)), 8'($urandom_range(255)),
                            16'($urandom_range(65535)), 16'($urandom_range(65535)));
    endtask

    // Random conversions, biased towards the divide and clamp boundaries
    task automatic test_random_conversions(input int count, input int s_pct, input int r_pct);
        logic [15:0] dk;
        logic [15:0] mv;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: dk = 16'($urandom_range(10239));
                4:          dk = 16'($urandom_range(10249, 10220));
                default:    dk = 16'($urandom_range(65535));
            endcase
            case ($urandom_range(9))
                0, 1:    mv = 16'($urandom_range(1499));
                2:       mv = 16'($urandom_range(1510, 1490));
                3, 4, 5: mv = 16'($urandom_range(20000, 1500));
                default: mv = 16'($urandom_range(65535));
            endcase
            send_conversion(8'($urandom_range(255)), 8'($urandom_range(255)), dk, mv);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n                          <= 1'b0;
        conv_ch.valid                  <= 1'b0;
        conv_ch.mux_register           <= 8'h00;
        conv_ch.control_b_register     <= 8'h00;
        conv_ch.temperature_decikelvin <= 16'h0000;
        conv_ch.supply_millivolts      <= 16'h0000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_thermal_edges();
        test_supply_and_alignment();
        test_result_stall();
        test_random_conversions(217, 13, 68);
        test_random_conversions(217, 68, 13);
        test_random_conversions(216, 0, 0);

        // drain
        conv_ch.valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d conversions (%0d thermal, %0d left aligned), %0d checked",
                 words_sent, thermal_count, left_count, words_checked);
        $display("Saturated readings %0d, clamped supplies %0d, errors %0d",
                 clipped_count, floored_count, error_count);
        if (error_count == 0 && predicted_results.size() == 0)
            $display("PASS adc_conversion_result_model_unit");
        else
            $display("FAIL adc_conversion_result_model_unit");
        $finish;
    end

endmodule
